FILE: rtl/cdnc_pkg.sv
// Package: frame geometry, widths, register map, FSM states and shared structs.
`default_nettype none
package cdnc_pkg;

    localparam int IMAGE_WIDTH  = 80;
    localparam int IMAGE_HEIGHT = 60;
    localparam int MAX_RADIUS   = 2;

    localparam int PIXELS  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W  = $clog2(PIXELS);
    localparam int CNT_W   = $clog2(PIXELS + 1);
    localparam int X_W     = $clog2(IMAGE_WIDTH);
    localparam int Y_W     = $clog2(IMAGE_HEIGHT);
    localparam int IY_W    = $clog2(IMAGE_HEIGHT + 1);
    localparam int R_W     = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W   = R_W + 1;
    localparam int BASE_W  = ADDR_W + 2;
    localparam int SUM_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

    localparam int PIX_W    = 14;
    localparam int THR_W    = 14;
    localparam int RADIUS_W = 2;
    localparam int MIN_W    = 5;
    localparam int OUT_X_W  = 7;
    localparam int OUT_Y_W  = 6;
    localparam int OUT_C_W  = 13;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_RADIUS    = 2'd1,
        REG_COUNT_MIN = 2'd2
    } reg_idx_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [THR_W-1:0]    threshold;
        logic [RADIUS_W-1:0] radius;
        logic [MIN_W-1:0]    count_min;
    } cfg_t;

    typedef struct packed {
        logic [OUT_X_W-1:0] x;
        logic [OUT_Y_W-1:0] y;
        logic               changed;
        logic               last;
        logic [OUT_C_W-1:0] count;
    } res_t;

endpackage
`default_nettype wire

FILE: rtl/cdnc_bitmap_ram.sv
// Single-bit change bitmap: one write port, one registered read port.
`default_nettype none
module cdnc_bitmap_ram
    import cdnc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic              wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic                   rdata
);

    logic mem [PIXELS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/cdnc_ctrl.sv
// Frame sequencer: bitmap writes, window sweep over the bitmap and result generation.
`default_nettype none
module cdnc_ctrl
    import cdnc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_cmd,
    input  wire logic [PIX_W-1:0] in_image,
    input  wire logic [PIX_W-1:0] in_baseline,
    input  wire logic             out_free,
    output logic                  res_load,
    output res_t                  res
);

    state_t state_reg, state_next;

    logic [X_W-1:0]    in_x_reg, in_x_next;
    logic [IY_W-1:0]   in_y_reg, in_y_next;
    logic [CNT_W-1:0]  in_lin_reg, in_lin_next;
    logic [X_W-1:0]    out_x_reg, out_x_next;
    logic [Y_W-1:0]    out_y_reg, out_y_next;
    logic [ADDR_W-1:0] out_lin_reg, out_lin_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;

    logic signed [OFS_W-1:0]  dx_reg, dx_next;
    logic signed [OFS_W-1:0]  dy_reg, dy_next;
    logic signed [BASE_W-1:0] row_base_reg, row_base_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;

    logic                     mem_we;
    logic                     in_full;
    logic                     change_bit;
    logic [PIX_W:0]           diff;
    logic [R_W-1:0]           eff_r;
    logic signed [OFS_W-1:0]  r_s;
    logic [X_W:0]             lx_sum, lx;
    logic [Y_W:0]             ly_sum, ly, iy_ext;
    logic                     win_ready;
    logic signed [Y_W+1:0]    yy;
    logic signed [X_W+1:0]    xx;
    logic signed [BASE_W-1:0] addr_s;
    logic                     tap_valid;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     rd_data;
    logic                     sweep_end;
    logic                     res_bit;
    logic                     res_last;
    logic [CNT_W-1:0]         cnt_sum;

    cdnc_bitmap_ram u_bitmap (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (in_lin_reg[ADDR_W-1:0]),
        .wdata (change_bit),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Raw change bit: saturating difference against the threshold.
    always_comb begin
        diff       = {1'b0, in_image} - {1'b0, in_baseline};
        change_bit = (in_image > in_baseline) && (diff[PIX_W-1:0] > cfg.threshold);
        in_full    = (in_y_reg == IY_W'(IMAGE_HEIGHT));
    end

    // Window geometry around the current output pixel.
    always_comb begin
        eff_r  = (int'(cfg.radius) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(cfg.radius);
        r_s    = $signed({1'b0, eff_r});
        lx_sum = {1'b0, out_x_reg} + (X_W+1)'(eff_r);
        lx     = (lx_sum > (X_W+1)'(IMAGE_WIDTH - 1)) ? (X_W+1)'(IMAGE_WIDTH - 1) : lx_sum;
        ly_sum = {1'b0, out_y_reg} + (Y_W+1)'(eff_r);
        ly     = (ly_sum > (Y_W+1)'(IMAGE_HEIGHT - 1)) ? (Y_W+1)'(IMAGE_HEIGHT - 1) : ly_sum;
        iy_ext = (Y_W+1)'(in_y_reg);
        // The window is complete once the input has moved past its bottom-right pixel.
        win_ready = (iy_ext > ly) || ((iy_ext == ly) && ({1'b0, in_x_reg} > lx));

        yy        = $signed({2'b00, out_y_reg}) + (Y_W+2)'(dy_reg);
        xx        = $signed({2'b00, out_x_reg}) + (X_W+2)'(dx_reg);
        addr_s    = row_base_reg + BASE_W'(dx_reg);
        tap_valid = (yy >= 0) && (yy < IMAGE_HEIGHT) && (xx >= 0) && (xx < IMAGE_WIDTH);
        rd_addr   = tap_valid ? addr_s[ADDR_W-1:0] : '0;
        sweep_end = (dx_reg == r_s) && (dy_reg == r_s);
    end

    always_comb begin
        res_bit  = int'(sum_reg) >= int'(cfg.count_min);
        res_last = (out_lin_reg == ADDR_W'(PIXELS - 1));
        cnt_sum  = run_cnt_reg + CNT_W'(res_bit);
        res.x       = OUT_X_W'(out_x_reg);
        res.y       = OUT_Y_W'(out_y_reg);
        res.changed = res_bit;
        res.last    = res_last;
        res.count   = res_last ? OUT_C_W'(cnt_sum) : '0;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CHECK;
            ST_CHECK: state_next = win_ready ? ST_SWEEP : ST_IDLE;
            ST_SWEEP: if (sweep_end) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready = 1'b0;
        res_load = 1'b0;
        mem_we   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                mem_we   = in_valid && (in_cmd == CMD_PIXEL) && !in_full;
            end
            ST_EMIT: res_load = out_free;
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb begin
        in_x_next     = in_x_reg;
        in_y_next     = in_y_reg;
        in_lin_next   = in_lin_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_lin_next  = out_lin_reg;
        run_cnt_next  = run_cnt_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        row_base_next = row_base_reg;
        rd_valid_next = (state_reg == ST_SWEEP) && tap_valid;
        sum_next      = sum_reg + SUM_W'(rd_valid_reg & rd_data);

        if (mem_we) begin
            in_lin_next = in_lin_reg + 1'b1;
            if (in_x_reg == X_W'(IMAGE_WIDTH - 1)) begin
                in_x_next = '0;
                in_y_next = in_y_reg + 1'b1;
            end else begin
                in_x_next = in_x_reg + 1'b1;
            end
        end

        if (state_reg == ST_CHECK) begin
            dx_next       = -r_s;
            dy_next       = -r_s;
            row_base_next = $signed({2'b00, out_lin_reg})
                            - $signed(BASE_W'(int'(eff_r) * IMAGE_WIDTH));
            sum_next      = '0;
        end

        if (state_reg == ST_SWEEP) begin
            if (dx_reg == r_s) begin
                dx_next       = -r_s;
                dy_next       = dy_reg + 1'b1;
                row_base_next = row_base_reg + BASE_W'(IMAGE_WIDTH);
            end else begin
                dx_next = dx_reg + 1'b1;
            end
        end

        if (res_load) begin
            if (res_last) begin
                // End of frame: every position counter starts over.
                in_x_next    = '0;
                in_y_next    = '0;
                in_lin_next  = '0;
                out_x_next   = '0;
                out_y_next   = '0;
                out_lin_next = '0;
                run_cnt_next = '0;
            end else begin
                run_cnt_next = cnt_sum;
                out_lin_next = out_lin_reg + 1'b1;
                if (out_x_reg == X_W'(IMAGE_WIDTH - 1)) begin
                    out_x_next = '0;
                    out_y_next = out_y_reg + 1'b1;
                end else begin
                    out_x_next = out_x_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_x_reg     <= '0;
            in_y_reg     <= '0;
            in_lin_reg   <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_lin_reg  <= '0;
            run_cnt_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_x_reg     <= in_x_next;
            in_y_reg     <= in_y_next;
            in_lin_reg   <= in_lin_next;
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
            out_lin_reg  <= out_lin_next;
            run_cnt_reg  <= run_cnt_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        row_base_reg <= row_base_next;
        sum_reg      <= sum_next;
    end

    // An output pixel is only produced once its own bit has been written.
    a_out_behind_in: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (CNT_W'(out_lin_reg) < in_lin_reg))
        else $error("output position not behind input position");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_load && res_last) |=> (in_lin_reg == '0) && (out_lin_reg == '0)
                                    && (run_cnt_reg == '0))
        else $error("counters not cleared after last pixel");

    // Bitmap reads never overlap a write of the same frame item.
    a_no_read_while_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !rd_valid_reg && (state_reg == ST_IDLE))
        else $error("bitmap write during window sweep");

    a_in_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        in_lin_reg <= CNT_W'(PIXELS))
        else $error("input position beyond frame");

endmodule
`default_nettype wire

FILE: rtl/change_detect_neighbor_count.sv
// Top level: APB register file, frame sequencer and registered result stage.
//
//  Channel   Direction  Handshake           Word
//  s_        in         s_valid / s_ready   cmd, image_value, baseline_value
//  m_        out        m_valid / m_ready   out_x, out_y, changed, last, changed_count
//  APB       in         psel / penable      registers at byte addresses 0, 4, 8
//
// An input word that yields a result starts a sweep over the (2r+1)^2 window taps,
// r being the effective window radius: one bitmap read per window tap on the single
// read port of the bitmap. No new word is taken until the result is loaded.
// A result waits in the output register while the next word is taken; a stall on
// m_ready holds the sequencer only when a further result is ready to load.
// Reset is synchronous; the bitmap needs no clearing since only bits already
// written in the current frame are read.
`default_nettype none
module change_detect_neighbor_count
    import cdnc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_cmd,
    input  wire logic [PIX_W-1:0]   s_image_value,
    input  wire logic [PIX_W-1:0]   s_baseline_value,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [OUT_X_W-1:0]      m_out_x,
    output logic [OUT_Y_W-1:0]      m_out_y,
    output logic                    m_changed,
    output logic                    m_last,
    output logic [OUT_C_W-1:0]      m_changed_count
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     apb_write;
    logic     m_valid_reg, m_valid_next;
    res_t     res_reg;
    res_t     res;
    logic     res_load;
    logic     out_free;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign apb_write = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (apb_write) begin
            unique case (reg_idx)
                REG_THRESHOLD: cfg_next.threshold = pwdata[THR_W-1:0];
                REG_RADIUS:    cfg_next.radius    = pwdata[RADIUS_W-1:0];
                REG_COUNT_MIN: cfg_next.count_min = pwdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = PDATA_W'(cfg_reg.threshold);
            REG_RADIUS:    prdata = PDATA_W'(cfg_reg.radius);
            REG_COUNT_MIN: prdata = PDATA_W'(cfg_reg.count_min);
            default:       prdata = '0;
        endcase
    end

    cdnc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_cmd      (s_cmd),
        .in_image    (s_image_value),
        .in_baseline (s_baseline_value),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= THR_W'(150);
            cfg_reg.radius    <= RADIUS_W'(1);
            cfg_reg.count_min <= MIN_W'(6);
            m_valid_reg       <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_x         = res_reg.x;
    assign m_out_y         = res_reg.y;
    assign m_changed       = res_reg.changed;
    assign m_last          = res_reg.last;
    assign m_changed_count = res_reg.count;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for change_detect_neighbor_count: random traffic against a predictor.
module tb_top;
    import cdnc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 15;
    localparam int PHASE_WORDS   = 55;
    localparam int LONG_HOLD     = 500;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] image;
        logic [PIX_W-1:0] baseline;
    } word_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic                 s_cmd            = CMD_FLUSH;
    logic [PIX_W-1:0]     s_image_value    = '0;
    logic [PIX_W-1:0]     s_baseline_value = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [OUT_X_W-1:0]   m_out_x;
    logic [OUT_Y_W-1:0]   m_out_y;
    logic                 m_changed;
    logic                 m_last;
    logic [OUT_C_W-1:0]   m_changed_count;

    // Predictor state: change bitmap, frame counters and a copy of the registers.
    bit                   change_map [PIXELS];
    int unsigned          pixels_in;
    int unsigned          pixels_out;
    int unsigned          set_count;
    logic [THR_W-1:0]     threshold_r = 150;
    logic [RADIUS_W-1:0]  radius_r    = 1;
    logic [MIN_W-1:0]     count_min_r = 6;

    res_t                 detections_due [$];
    word_t                words_pending [$];
    int unsigned          words_queued   = 0;
    int unsigned          words_accepted = 0;
    int unsigned          words_taken    = 0;
    int                   send_wait      = 0;
    int                   take_wait      = 0;
    int                   error_count    = 0;
    int unsigned          cycle_count    = 0;
    bit                   steady         = 1'b0;

    change_detect_neighbor_count DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_image_value    (s_image_value),
        .s_baseline_value (s_baseline_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_changed        (m_changed),
        .m_last           (m_last),
        .m_changed_count  (m_changed_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stores the changed bit of a pixel word and releases the next output pixel
    // once every pixel of its window has arrived.
    task automatic compute_detection(input logic cmd, input logic [PIX_W-1:0] image,
                                     input logic [PIX_W-1:0] baseline);
        int   r;
        int   x;
        int   y;
        int   xx;
        int   yy;
        int   last_x;
        int   last_y;
        int   taps_set;
        res_t res;
        if (cmd == CMD_PIXEL && pixels_in < PIXELS) begin
            change_map[pixels_in] = (image > baseline) && ((image - baseline) > threshold_r);
            pixels_in++;
        end
        if (pixels_out >= PIXELS)
            return;
        r      = (radius_r > MAX_RADIUS) ? MAX_RADIUS : int'(radius_r);
        x      = pixels_out % IMAGE_WIDTH;
        y      = pixels_out / IMAGE_WIDTH;
        last_x = (x + r > IMAGE_WIDTH - 1) ? IMAGE_WIDTH - 1 : x + r;
        last_y = (y + r > IMAGE_HEIGHT - 1) ? IMAGE_HEIGHT - 1 : y + r;
        if (pixels_in <= last_y * IMAGE_WIDTH + last_x)
            return;
        taps_set = 0;
        for (yy = y - r; yy <= y + r; yy++) begin
            for (xx = x - r; xx <= x + r; xx++) begin
                if (yy >= 0 && yy < IMAGE_HEIGHT && xx >= 0 && xx < IMAGE_WIDTH)
                    taps_set += change_map[yy * IMAGE_WIDTH + xx];
            end
        end
        res.x       = OUT_X_W'(x);
        res.y       = OUT_Y_W'(y);
        res.changed = (taps_set >= count_min_r);
        set_count  += res.changed;
        res.last    = (pixels_out == PIXELS - 1);
        res.count   = res.last ? OUT_C_W'(set_count) : '0;
        detections_due.push_back(res);
        pixels_out++;
        if (res.last) begin
            pixels_in  = 0;
            pixels_out = 0;
            set_count  = 0;
        end
    endtask

    task automatic push_word(input logic cmd, input logic [PIX_W-1:0] image,
                             input logic [PIX_W-1:0] baseline);
        word_t w;
        w.cmd      = cmd;
        w.image    = image;
        w.baseline = baseline;
        words_pending.push_back(w);
        words_queued++;
    endtask

    // Mostly pixels near the threshold, with full-range and saturating cases mixed in.
    function automatic word_t random_pixel();
        word_t w;
        w.cmd = CMD_PIXEL;
        case ($urandom_range(0, 9))
            0: begin
                w.image    = PIX_W'($urandom);
                w.baseline = PIX_W'($urandom);
            end
            1: begin
                w.image    = '1;
                w.baseline = PIX_W'($urandom_range(0, 16383));
            end
            2: begin
                w.baseline = PIX_W'($urandom_range(1, 16383));
                w.image    = PIX_W'($urandom_range(0, w.baseline - 1));
            end
            default: begin
                w.baseline = PIX_W'($urandom_range(0, 15583));
                w.image    = w.baseline + PIX_W'($urandom_range(0, 800));
            end
        endcase
        return w;
    endfunction

    // Waits until every word is taken and every result is out, then lets the
    // sequencer finish with any last word that produced no result.
    task automatic settle();
        while (words_accepted != words_queued || detections_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input reg_idx_t idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        apb_access(1'b1, idx, value, readback);
        apb_access(1'b0, idx, '0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_THRESHOLD: threshold_r = value[THR_W-1:0];
            REG_RADIUS:    radius_r    = value[RADIUS_W-1:0];
            REG_COUNT_MIN: count_min_r = value[MIN_W-1:0];
            default: ;
        endcase
        if (readback !== value) begin
            $error("%s readback mismatch: expected %0d, got %0d", idx.name(), value, readback);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : driver
        word_t w;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait  = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                compute_detection(s_cmd, s_image_value, s_baseline_value);
                words_accepted++;
            end
            if (send_wait == 0 && words_pending.size() > 0) begin
                w = words_pending.pop_front();
                s_valid          <= 1'b1;
                s_cmd            <= w.cmd;
                s_image_value    <= w.image;
                s_baseline_value <= w.baseline;
                send_wait         = steady ? 0 : $urandom_range(0, 5);
            end else begin
                s_valid <= 1'b0;
                if (send_wait > 0)
                    send_wait--;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        res_t due;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            take_wait  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (detections_due.size() == 0) begin
                    $error("unexpected word: x=%0d y=%0d", m_out_x, m_out_y);
                    error_count++;
                end else begin
                    due = detections_due.pop_front();
                    if (m_out_x !== due.x) begin
                        $error("out_x mismatch: expected %0d, got %0d", due.x, m_out_x);
                        error_count++;
                    end
                    if (m_out_y !== due.y) begin
                        $error("out_y mismatch: expected %0d, got %0d", due.y, m_out_y);
                        error_count++;
                    end
                    if (m_changed !== due.changed) begin
                        $error("changed mismatch: expected %0d, got %0d", due.changed, m_changed);
                        error_count++;
                    end
                    if (m_last !== due.last) begin
                        $error("last mismatch: expected %0d, got %0d", due.last, m_last);
                        error_count++;
                    end
                    if (m_changed_count !== due.count) begin
                        $error("changed_count mismatch: expected %0d, got %0d",
                               due.count, m_changed_count);
                        error_count++;
                    end
                end
                words_taken++;
                take_wait = steady ? 0 : $urandom_range(0, 5);
                // Now and then stop taking results long enough for the block to back up.
                if (words_taken % 200 == 100)
                    take_wait = LONG_HOLD;
            end
            if (take_wait > 0) begin
                take_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL change_detect_neighbor_count");
            $finish;
        end
    end

    initial begin : stimulus
        int    phase;
        int    i;
        int    eff_r;
        int    taps;
        word_t w;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_register(REG_THRESHOLD, 150);
        write_register(REG_RADIUS, 1);
        write_register(REG_COUNT_MIN, 6);
        // Flushes at the start of a frame have no complete window and give nothing.
        push_word(CMD_FLUSH, '1, '0);
        push_word(CMD_FLUSH, '0, '1);
        push_word(CMD_PIXEL, 16383, 0);
        push_word(CMD_PIXEL, 0, 16383);
        push_word(CMD_PIXEL, 0, 0);
        push_word(CMD_PIXEL, 16383, 16383);
        push_word(CMD_PIXEL, 300, 150);
        push_word(CMD_PIXEL, 301, 150);
        push_word(CMD_PIXEL, 150, 0);
        push_word(CMD_PIXEL, 151, 0);
        push_word(CMD_PIXEL, 16383, 16233);
        push_word(CMD_FLUSH, 16383, 16383);
        push_word(CMD_PIXEL, 16383, 16232);
        push_word(CMD_PIXEL, 5461, 10922);
        push_word(CMD_PIXEL, 10922, 5461);
        settle();

        // Radius above the limit, zero threshold and zero count minimum.
        write_register(REG_THRESHOLD, 0);
        write_register(REG_RADIUS, 3);
        write_register(REG_COUNT_MIN, 0);
        push_word(CMD_PIXEL, 1, 0);
        push_word(CMD_PIXEL, 0, 0);
        push_word(CMD_PIXEL, 7, 7);
        push_word(CMD_FLUSH, 0, 0);
        push_word(CMD_PIXEL, 16383, 1);
        settle();

        // Top threshold can never be exceeded; count minimum above any window.
        write_register(REG_THRESHOLD, 16383);
        write_register(REG_RADIUS, 0);
        write_register(REG_COUNT_MIN, 31);
        push_word(CMD_PIXEL, 16383, 0);
        push_word(CMD_PIXEL, 12345, 2);
        push_word(CMD_PIXEL, 0, 16383);

        // The random phases change the settings many times over the first rows of a frame.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            steady = (phase % 5 == 4);
            if (phase == 1)
                write_register(REG_THRESHOLD, 16383);
            else if (phase % 6 == 3)
                write_register(REG_THRESHOLD, 0);
            else if (phase % 6 == 5)
                write_register(REG_THRESHOLD, $urandom_range(0, 16383));
            else
                write_register(REG_THRESHOLD, $urandom_range(50, 400));
            if (phase == 2 || phase == 7)
                write_register(REG_RADIUS, 0);
            else
                write_register(REG_RADIUS, $urandom_range(1, 3));
            eff_r = (radius_r > MAX_RADIUS) ? MAX_RADIUS : int'(radius_r);
            taps  = (2 * eff_r + 1) * (2 * eff_r + 1);
            case (phase % 7)
                0:       write_register(REG_COUNT_MIN, 0);
                1:       write_register(REG_COUNT_MIN, 31);
                4:       write_register(REG_COUNT_MIN, taps);
                6:       write_register(REG_COUNT_MIN, 25);
                default: write_register(REG_COUNT_MIN, $urandom_range(1, taps));
            endcase
            for (i = 0; i < PHASE_WORDS; i++) begin
                w = random_pixel();
                if ($urandom_range(0, 99) < 8)
                    push_word(CMD_FLUSH, w.image, w.baseline);
                else
                    push_word(CMD_PIXEL, w.image, w.baseline);
            end
        end

        steady = 1'b0;
        settle();
        if (error_count == 0 && detections_due.size() == 0)
            $display("PASS change_detect_neighbor_count");
        else
            $display("FAIL change_detect_neighbor_count");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cdnc_pkg.sv
rtl/cdnc_bitmap_ram.sv
rtl/cdnc_ctrl.sv
rtl/change_detect_neighbor_count.sv
sim/tb_top.sv
